FILE: rtl/core/ldc_pkg.sv
`timescale 1ns / 1ps
package ldc_pkg;

  localparam int LAYER_COUNT = 16;
  localparam int BOARD_COUNT = 8;
  localparam int DIGIT_COUNT = 8;
  localparam int MAX_RESULTS = 8;

  localparam int LID_W   = 4;
  localparam int BRD_W   = 3;
  localparam int DIG_W   = 3;
  localparam int DADDR_W = LID_W + DIG_W;
  localparam int DDEPTH  = LAYER_COUNT * DIGIT_COUNT;
  localparam int CNT_W   = 4;

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_DRAW  = 3'd1;
  localparam logic [2:0] OP_PUSH  = 3'd2;
  localparam logic [2:0] OP_POP   = 3'd3;
  localparam logic [2:0] OP_ALPHA = 3'd4;

  localparam logic [7:0] ALL_ONES = 8'hff;

  // One result item as it leaves the sequencer.
  typedef struct packed {
    logic [BRD_W-1:0] board;
    logic [DIG_W-1:0] digit;
    logic [7:0]       segments;
    logic             row_clear;
    logic             op_error;
    logic             last;
  } res_t;

endpackage

FILE: rtl/core/ldc_ram.sv
`timescale 1ns / 1ps
module ldc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/ldc_ctrl.sv
`timescale 1ns / 1ps
module ldc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  opcode,
  input  logic [ldc_pkg::LID_W-1:0]   layer_id,
  input  logic [ldc_pkg::BRD_W-1:0]   target_board,
  input  logic [ldc_pkg::DIG_W-1:0]   digit_slot,
  input  logic [7:0]                  digit_segments,
  input  logic [7:0]                  alpha_bits,
  output logic                        ram_we,
  output logic [ldc_pkg::DADDR_W-1:0] ram_waddr,
  output logic [7:0]                  ram_wdata,
  output logic                        ram_re,
  output logic [ldc_pkg::DADDR_W-1:0] ram_raddr,
  input  logic [7:0]                  ram_rdata,
  input  logic                        out_free,
  output logic                        push,
  output ldc_pkg::res_t               push_res
);
  import ldc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_DRD  = 3'd2;
  localparam logic [2:0] ST_DWR  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [7:0]       alpha_r  [LAYER_COUNT];
  logic [7:0]       mask_r   [LAYER_COUNT];
  logic [BRD_W-1:0] board_r  [LAYER_COUNT];
  logic             att_r    [LAYER_COUNT];
  logic [LID_W-1:0] below_r  [LAYER_COUNT];
  logic             hasb_r   [LAYER_COUNT];
  logic [LID_W-1:0] top_r    [BOARD_COUNT];
  logic             nonemp_r [BOARD_COUNT];
  logic [DDEPTH-1:0] dval_r;

  logic [LID_W-1:0] cur_r;
  logic [LID_W-1:0] id_r;
  logic [DIG_W-1:0] d_r;
  logic [7:0]       left_r;
  logic             redraw_r;
  logic             draw_after_r;
  logic             dv_q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pend_v_r;
  res_t             pend_r;

  logic             accept;
  logic             vis;
  logic             want_emit;
  logic             stall;
  logic [BRD_W-1:0] pb;
  res_t             new_res;
  res_t             err_res;
  res_t             clr_res;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign pb       = board_r[layer_id];

  // Digit visibility and emission gating while drawing.
  assign vis       = mask_r[cur_r][3'd7 - d_r];
  assign want_emit = vis && (cnt_r < CNT_W'(MAX_RESULTS));
  assign stall     = want_emit && pend_v_r && !out_free;

  always_comb begin
    new_res           = '0;
    new_res.board     = board_r[cur_r];
    new_res.digit     = d_r;
    new_res.segments  = dv_q_r ? ram_rdata : 8'h00;
  end

  // Error and row clear items built at acceptance.
  always_comb begin
    err_res           = '0;
    err_res.op_error  = 1'b1;
    clr_res           = '0;
    clr_res.board     = pb;
    clr_res.row_clear = 1'b1;
  end

  // Digit store port use.
  assign ram_we    = accept && (opcode == OP_WRITE);
  assign ram_waddr = {layer_id, digit_slot};
  assign ram_wdata = digit_segments;
  assign ram_re    = (state_r == ST_DRD);
  assign ram_raddr = {cur_r, d_r};

  // Results leave the pending slot once a later one arrives or the item ends.
  always_comb begin
    push     = 1'b0;
    push_res = pend_r;
    if (state_r == ST_DWR && want_emit && pend_v_r && out_free) begin
      push          = 1'b1;
      push_res.last = 1'b0;
    end else if (state_r == ST_DONE && pend_v_r && out_free) begin
      push          = 1'b1;
      push_res.last = 1'b1;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DONE;
          if (opcode == OP_DRAW && att_r[layer_id]) begin
            state_nxt = ST_DRD;
          end else if (opcode == OP_PUSH && !att_r[layer_id]) begin
            state_nxt = ST_WALK;
          end else if (opcode == OP_POP && att_r[layer_id] && nonemp_r[pb] &&
                       top_r[pb] == layer_id && hasb_r[layer_id]) begin
            state_nxt = ST_WALK;
          end else if (opcode == OP_ALPHA && att_r[layer_id] && nonemp_r[pb]) begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (redraw_r) begin
          state_nxt = ST_DRD;
        end else if (hasb_r[cur_r]) begin
          state_nxt = ST_WALK;
        end else if (draw_after_r) begin
          state_nxt = ST_DRD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DRD: state_nxt = ST_DWR;
      ST_DWR: begin
        if (!stall) begin
          if (d_r != DIG_W'(DIGIT_COUNT - 1)) begin
            state_nxt = ST_DRD;
          end else if (redraw_r && hasb_r[cur_r]) begin
            state_nxt = ST_WALK;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!pend_v_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State registers and layer bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      dval_r       <= '0;
      pend_v_r     <= 1'b0;
      cnt_r        <= '0;
      redraw_r     <= 1'b0;
      draw_after_r <= 1'b0;
      for (int i = 0; i < LAYER_COUNT; i++) begin
        alpha_r[i] <= ALL_ONES;
        mask_r[i]  <= '0;
        board_r[i] <= '0;
        att_r[i]   <= 1'b0;
        below_r[i] <= '0;
        hasb_r[i]  <= 1'b0;
      end
      for (int b = 0; b < BOARD_COUNT; b++) begin
        top_r[b]    <= '0;
        nonemp_r[b] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            id_r         <= layer_id;
            cur_r        <= layer_id;
            d_r          <= '0;
            left_r       <= ALL_ONES;
            cnt_r        <= '0;
            redraw_r     <= 1'b0;
            draw_after_r <= 1'b0;
            unique case (opcode)
              OP_WRITE: dval_r[{layer_id, digit_slot}] <= 1'b1;
              OP_PUSH: begin
                if (att_r[layer_id]) begin
                  pend_v_r <= 1'b1;
                  pend_r   <= err_res;
                  cnt_r    <= CNT_W'(1);
                end else begin
                  board_r[layer_id]      <= target_board;
                  hasb_r[layer_id]       <= nonemp_r[target_board];
                  below_r[layer_id]      <= nonemp_r[target_board] ?
                                            top_r[target_board] : '0;
                  att_r[layer_id]        <= 1'b1;
                  top_r[target_board]    <= layer_id;
                  nonemp_r[target_board] <= 1'b1;
                  draw_after_r           <= 1'b1;
                end
              end
              OP_POP: begin
                if (!att_r[layer_id] || !nonemp_r[pb] || top_r[pb] != layer_id) begin
                  pend_v_r <= 1'b1;
                  pend_r   <= err_res;
                  cnt_r    <= CNT_W'(1);
                end else begin
                  if (!hasb_r[layer_id]) begin
                    pend_v_r     <= 1'b1;
                    pend_r       <= clr_res;
                    cnt_r        <= CNT_W'(1);
                    nonemp_r[pb] <= 1'b0;
                    top_r[pb]    <= '0;
                  end else begin
                    top_r[pb] <= below_r[layer_id];
                    cur_r     <= below_r[layer_id];
                    redraw_r  <= 1'b1;
                  end
                  att_r[layer_id]   <= 1'b0;
                  hasb_r[layer_id]  <= 1'b0;
                  below_r[layer_id] <= '0;
                end
              end
              OP_ALPHA: begin
                alpha_r[layer_id] <= alpha_bits;
                if (att_r[layer_id] && nonemp_r[pb]) begin
                  cur_r    <= top_r[pb];
                  redraw_r <= 1'b1;
                end else begin
                  mask_r[layer_id] <= alpha_bits;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          // One layer of the stack per cycle, top down.
          mask_r[cur_r] <= left_r & alpha_r[cur_r];
          left_r        <= left_r & ~alpha_r[cur_r];
          d_r           <= '0;
          if (!redraw_r) begin
            if (hasb_r[cur_r]) begin
              cur_r <= below_r[cur_r];
            end else begin
              cur_r <= id_r;
            end
          end
        end
        ST_DRD: begin
          dv_q_r <= dval_r[{cur_r, d_r}];
        end
        ST_DWR: begin
          if (!stall) begin
            if (want_emit) begin
              pend_v_r <= 1'b1;
              pend_r   <= new_res;
              cnt_r    <= cnt_r + CNT_W'(1);
            end
            d_r <= d_r + DIG_W'(1);
            if (d_r == DIG_W'(DIGIT_COUNT - 1) && redraw_r && hasb_r[cur_r]) begin
              cur_r <= below_r[cur_r];
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            pend_v_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/layered_digit_display_compositor_unit.sv
`timescale 1ns / 1ps
// After acceptance the sequencer rebuilds the mask of each layer it walks in a walk state
// and scans each digit position with a read state and then a write state; a result waits
// in a pending slot until the next one is found or the item ends, then passes through one
// output register. One item at a time: a new one is taken only once the last is done, and
// its time grows with stack depth, the eight digit reads per drawn layer and output stalls.
// Reset: rst_n synchronous, active low; empties all stacks, sets alpha to all ones and
// marks every stored digit as zero at once, with no clearing pass.
module layered_digit_display_compositor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[2:0], layer_id[6:3], target_board[9:7], digit_slot[12:10],
  // digit_segments[20:13], alpha_bits[28:21], zero fill [31:29]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_board[2:0], out_digit[5:3], out_segments[13:6], zero fill [15:14]
  output logic [15:0] out_tdata,
  // row_clear[0], op_error[1]
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);
  import ldc_pkg::*;

  logic               ram_we;
  logic [DADDR_W-1:0] ram_waddr;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [DADDR_W-1:0] ram_raddr;
  logic [7:0]         ram_rdata;
  logic               out_free;
  logic               push;
  res_t               push_res;
  logic               out_v_r;
  res_t               out_r;

  ldc_ram #(.WIDTH(8), .DEPTH(DDEPTH)) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ldc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .opcode         (in_tdata[2:0]),
    .layer_id       (in_tdata[6:3]),
    .target_board   (in_tdata[9:7]),
    .digit_slot     (in_tdata[12:10]),
    .digit_segments (in_tdata[20:13]),
    .alpha_bits     (in_tdata[28:21]),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_free       (out_free),
    .push           (push),
    .push_res       (push_res)
  );

  // Output register; it frees up in the cycle its item is taken.
  assign out_free = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r <= push_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_r.segments, out_r.digit, out_r.board};
  assign out_tuser  = {out_r.op_error, out_r.row_clear};
  assign out_tlast  = out_r.last;

endmodule
